@@ src/bdhr_pkg.sv @@
// shared types and constants for the button debounce, hold and repeat block
package bdhr_pkg;

	// number of buttons served and the widths that follow from it
	localparam int NUM_BUTTONS = 8;
	localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int SWEEP_CNT_W = $clog2(NUM_BUTTONS + 1);

	// register reset values
	localparam logic [15:0] DEBOUNCE_RST = 16'd40;
	localparam logic [15:0] HOLD_RST     = 16'd2000;
	localparam logic [15:0] REPEAT_RST   = 16'd3000;
	localparam logic [7:0]  POL_RST      = 8'd0;

	// register indexes (byte address divided by four)
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_HOLD     = 2'd1;
	localparam logic [1:0] REG_REPEAT   = 2'd2;
	localparam logic [1:0] REG_POLARITY = 2'd3;

	// input word kinds carried in tuser
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	typedef enum logic [2:0] {
		EV_PRESSED  = 3'd0,
		EV_RELEASED = 3'd1,
		EV_HOLD     = 3'd2,
		EV_REPEAT   = 3'd3,
		EV_CLICK    = 3'd4
	} ev_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_SMP
	} ctl_state_t;

	// per-button state held in one memory entry
	typedef struct packed {
		logic        stable;
		logic        deb_active;
		logic        pending;
		logic [15:0] deb_left;
		logic        deb_done;
		logic        hold_active;
		logic [15:0] hold_left;
		logic        hold_done;
		logic        rep_active;
		logic [15:0] rep_left;
		logic        rep_done;
	} btn_state_t;

endpackage

@@ src/button_debounce_hold_repeat_top.sv @@
// top level of the button debounce, hold and repeat qualifier
// Qualifies up to bdhr_pkg::NUM_BUTTONS push buttons. Each input word is either a pin
// sample for one button (tuser low) or a timer tick for all buttons (tuser high). All
// per-button state sits in one memory with registered read, so every word is a
// read-modify-write of that memory. A sample is read, then updated and written back, and
// yields up to two event words (released is followed by click when hold had not yet
// been reported); the update waits until earlier events have been taken. A tick sweeps
// the memory, one button a cycle with read and write overlapped; it yields no events.
// Events leave at one word a cycle while m_tready is high, tlast marks the final event
// of a sample. The memory needs no clearing pass after reset: per-entry valid bits make
// unwritten entries read as the released, idle state.
// Register map: 0x0 debounce ticks, 0x4 hold ticks, 0x8 repeat ticks, 0xC polarity mask.
module button_debounce_hold_repeat_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [2:0] button, [3] pin_level, [7:4] zero
	input  logic        s_tuser,   // [0] kind
	// event stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [2:0] event_button, [5:3] event_code, [7:6] zero
	output logic        m_tlast,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [15:0] deb_ticks_q;
	logic [15:0] hold_ticks_q;
	logic [15:0] rep_ticks_q;
	logic [7:0]  pol_mask_q;
	logic [1:0]  reg_idx;
	logic        cfg_wr;

	// control
	bdhr_pkg::ctl_state_t state_q, state_d;
	logic [bdhr_pkg::SWEEP_CNT_W-1:0] cnt_q, cnt_d;
	logic [2:0] btn_q;
	logic       pin_q;
	logic       in_acc;
	logic       in_range;

	// state memory
	bdhr_pkg::btn_state_t mem [bdhr_pkg::NUM_BUTTONS];
	logic [bdhr_pkg::NUM_BUTTONS-1:0] vld_q;
	bdhr_pkg::btn_state_t rd_data_q;
	logic                 rd_vld_q;
	logic                 rd_en;
	logic [bdhr_pkg::BTN_IDX_W-1:0] rd_addr;
	logic                 wr_en;
	logic [bdhr_pkg::BTN_IDX_W-1:0] wr_addr;
	bdhr_pkg::btn_state_t wr_data;
	bdhr_pkg::btn_state_t cur;
	bdhr_pkg::btn_state_t tick_nxt;
	bdhr_pkg::btn_state_t smp_nxt;

	// sample update results
	logic               pressed;
	logic [1:0]         ev_cnt;
	bdhr_pkg::ev_code_t ev0, ev1;

	// event buffer
	logic [1:0]         out_cnt_q;
	bdhr_pkg::ev_code_t head_q, tail_q;
	logic [2:0]         out_btn_q;
	logic               load_out;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_ticks_q  <= bdhr_pkg::DEBOUNCE_RST;
			hold_ticks_q <= bdhr_pkg::HOLD_RST;
			rep_ticks_q  <= bdhr_pkg::REPEAT_RST;
			pol_mask_q   <= bdhr_pkg::POL_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				bdhr_pkg::REG_DEBOUNCE: deb_ticks_q  <= pwdata[15:0];
				bdhr_pkg::REG_HOLD:     hold_ticks_q <= pwdata[15:0];
				bdhr_pkg::REG_REPEAT:   rep_ticks_q  <= pwdata[15:0];
				bdhr_pkg::REG_POLARITY: pol_mask_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			bdhr_pkg::REG_DEBOUNCE: prdata = {16'd0, deb_ticks_q};
			bdhr_pkg::REG_HOLD:     prdata = {16'd0, hold_ticks_q};
			bdhr_pkg::REG_REPEAT:   prdata = {16'd0, rep_ticks_q};
			bdhr_pkg::REG_POLARITY: prdata = {24'd0, pol_mask_q};
			default:                prdata = 32'd0;
		endcase
	end

	// input handshake
	assign s_tready = (state_q == bdhr_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_range = (32'(s_tdata[2:0]) < bdhr_pkg::NUM_BUTTONS);

	// entry as read, unwritten entries read as all zero
	assign cur = rd_vld_q ? rd_data_q : '0;

	// tick: count every timer of one entry down
	always_comb begin
		tick_nxt = cur;
		if (cur.deb_left != 16'd0) tick_nxt.deb_left = cur.deb_left - 16'd1;
		else                       tick_nxt.deb_done = 1'b1;
		if (cur.hold_left != 16'd0) tick_nxt.hold_left = cur.hold_left - 16'd1;
		else                        tick_nxt.hold_done = 1'b1;
		if (cur.rep_left != 16'd0) tick_nxt.rep_left = cur.rep_left - 16'd1;
		else                       tick_nxt.rep_done = 1'b1;
	end

	// sample: debounce, press and release, hold and repeat
	always_comb begin
		smp_nxt = cur;
		pressed = (pin_q == pol_mask_q[btn_q]);
		ev_cnt  = 2'd0;
		ev0     = bdhr_pkg::EV_PRESSED;
		ev1     = bdhr_pkg::EV_PRESSED;

		// level compare against confirmed level
		if (pressed == smp_nxt.stable) begin
			if (smp_nxt.deb_active && smp_nxt.deb_done) begin
				smp_nxt.deb_active = 1'b0;
				smp_nxt.pending    = 1'b1;
			end
		end else if (!smp_nxt.deb_active) begin
			smp_nxt.stable     = pressed;
			smp_nxt.pending    = 1'b1;
			smp_nxt.deb_left   = deb_ticks_q;
			smp_nxt.deb_done   = 1'b0;
			smp_nxt.deb_active = 1'b1;
		end else begin
			smp_nxt.deb_active = 1'b0;
			smp_nxt.pending    = 1'b0;
		end

		// confirmed change
		if (smp_nxt.pending && smp_nxt.deb_done) begin
			smp_nxt.stable     = pressed;
			smp_nxt.deb_active = 1'b0;
			smp_nxt.pending    = 1'b0;
			if (pressed) begin
				ev0                 = bdhr_pkg::EV_PRESSED;
				ev_cnt              = 2'd1;
				smp_nxt.hold_left   = hold_ticks_q;
				smp_nxt.hold_done   = 1'b0;
				smp_nxt.hold_active = 1'b1;
				smp_nxt.rep_active  = 1'b0;
			end else begin
				ev0    = bdhr_pkg::EV_RELEASED;
				ev_cnt = 2'd1;
				if (smp_nxt.hold_active) begin
					ev1    = bdhr_pkg::EV_CLICK;
					ev_cnt = 2'd2;
				end
				smp_nxt.hold_active = 1'b0;
				smp_nxt.rep_active  = 1'b0;
			end
		end

		// hold time reached
		if (smp_nxt.stable && smp_nxt.hold_active && !smp_nxt.rep_active &&
				smp_nxt.hold_done) begin
			if (ev_cnt == 2'd0) ev0 = bdhr_pkg::EV_HOLD;
			else                ev1 = bdhr_pkg::EV_HOLD;
			ev_cnt              = ev_cnt + 2'd1;
			smp_nxt.hold_active = 1'b0;
			smp_nxt.rep_left    = rep_ticks_q;
			smp_nxt.rep_done    = 1'b0;
			smp_nxt.rep_active  = 1'b1;
		end

		// repeat period reached
		if (smp_nxt.stable && !smp_nxt.hold_active && smp_nxt.rep_active &&
				smp_nxt.rep_done) begin
			if (ev_cnt == 2'd0) ev0 = bdhr_pkg::EV_REPEAT;
			else                ev1 = bdhr_pkg::EV_REPEAT;
			ev_cnt           = ev_cnt + 2'd1;
			smp_nxt.rep_left = rep_ticks_q;
			smp_nxt.rep_done = 1'b0;
		end
	end

	// sequencer: next state and memory access
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = tick_nxt;
		load_out = 1'b0;
		unique case (state_q)
			bdhr_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser == bdhr_pkg::KIND_TICK) begin
						rd_en   = 1'b1;
						rd_addr = '0;
						cnt_d   = bdhr_pkg::SWEEP_CNT_W'(1);
						state_d = bdhr_pkg::ST_TICK;
					end else if (in_range) begin
						rd_en   = 1'b1;
						rd_addr = bdhr_pkg::BTN_IDX_W'(s_tdata[2:0]);
						state_d = bdhr_pkg::ST_SMP;
					end
				end
			end
			bdhr_pkg::ST_TICK: begin
				// write back the previous entry while reading the next one
				wr_en   = 1'b1;
				wr_addr = bdhr_pkg::BTN_IDX_W'(cnt_q - bdhr_pkg::SWEEP_CNT_W'(1));
				wr_data = tick_nxt;
				if (cnt_q < bdhr_pkg::SWEEP_CNT_W'(bdhr_pkg::NUM_BUTTONS)) begin
					rd_en   = 1'b1;
					rd_addr = cnt_q[bdhr_pkg::BTN_IDX_W-1:0];
					cnt_d   = cnt_q + bdhr_pkg::SWEEP_CNT_W'(1);
				end else begin
					state_d = bdhr_pkg::ST_IDLE;
				end
			end
			bdhr_pkg::ST_SMP: begin
				// update once the event buffer has drained
				if (out_cnt_q == 2'd0) begin
					wr_en    = 1'b1;
					wr_addr  = bdhr_pkg::BTN_IDX_W'(btn_q);
					wr_data  = smp_nxt;
					load_out = 1'b1;
					state_d  = bdhr_pkg::ST_IDLE;
				end
			end
			default: state_d = bdhr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdhr_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// captured sample fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			btn_q <= s_tdata[2:0];
			pin_q <= s_tdata[3];
		end
	end

	// state memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// valid bits stand in for the reset of the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_addr] <= 1'b1;
			if (rd_en) rd_vld_q <= vld_q[rd_addr];
		end
	end

	// event buffer, up to two words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (load_out) begin
			out_cnt_q <= ev_cnt;
		end else if (m_tvalid && m_tready) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			head_q    <= ev0;
			tail_q    <= ev1;
			out_btn_q <= btn_q;
		end else if (m_tvalid && m_tready) begin
			head_q <= tail_q;
		end
	end

	// event port
	assign m_tvalid = (out_cnt_q != 2'd0);
	assign m_tlast  = (out_cnt_q == 2'd1);
	assign m_tdata  = {2'b00, head_q, out_btn_q};

endmodule

@@ tb/button_debounce_hold_repeat_top_tb.sv @@
// testbench for the button debounce, hold and repeat qualifier with its own event predictor
module button_debounce_hold_repeat_top_tb;
	import bdhr_pkg::*;

	localparam int SETTLE_CYCLES = 2 * NUM_BUTTONS + 8;
	localparam int DRAIN_LIMIT   = 4000;

	// one expected event word
	typedef struct {
		logic [2:0] btn;
		ev_code_t   code;
		bit         last;
	} btn_event_t;

	// button qualifier predictor and the queue of events it still waits for
	class btn_qualifier_model;
		logic [15:0] deb_len;
		logic [15:0] hold_len;
		logic [15:0] rep_len;
		logic [7:0]  high_mask;
		bit          level_q[NUM_BUTTONS];
		bit          deb_run[NUM_BUTTONS];
		bit          chg_wait[NUM_BUTTONS];
		logic [15:0] deb_cnt[NUM_BUTTONS];
		bit          deb_end[NUM_BUTTONS];
		bit          hold_run[NUM_BUTTONS];
		logic [15:0] hold_cnt[NUM_BUTTONS];
		bit          hold_end[NUM_BUTTONS];
		bit          rep_run[NUM_BUTTONS];
		logic [15:0] rep_cnt[NUM_BUTTONS];
		bit          rep_end[NUM_BUTTONS];
		btn_event_t  pending[$];
		int          errors;

		function new();
			deb_len   = DEBOUNCE_RST;
			hold_len  = HOLD_RST;
			rep_len   = REPEAT_RST;
			high_mask = POL_RST;
			errors    = 0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				level_q[i]  = 0;
				deb_run[i]  = 0;
				chg_wait[i] = 0;
				deb_cnt[i]  = '0;
				deb_end[i]  = 0;
				hold_run[i] = 0;
				hold_cnt[i] = '0;
				hold_end[i] = 0;
				rep_run[i]  = 0;
				rep_cnt[i]  = '0;
				rep_end[i]  = 0;
			end
		endfunction

		// register write, only the register width is kept
		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_DEBOUNCE: deb_len   = val[15:0];
				REG_HOLD:     hold_len  = val[15:0];
				REG_REPEAT:   rep_len   = val[15:0];
				REG_POLARITY: high_mask = val[7:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [1:0] idx);
			case (idx)
				REG_DEBOUNCE: return {16'd0, deb_len};
				REG_HOLD:     return {16'd0, hold_len};
				REG_REPEAT:   return {16'd0, rep_len};
				default:      return {24'd0, high_mask};
			endcase
		endfunction

		// accepted input word: update the button state and queue the events it causes
		function void note_word(logic kind, logic [2:0] b, logic pin);
			bit         pressed;
			btn_event_t run[$];
			if (kind == KIND_TICK) begin
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (deb_cnt[i] != 0) deb_cnt[i] = deb_cnt[i] - 1'b1;
					else deb_end[i] = 1;
					if (hold_cnt[i] != 0) hold_cnt[i] = hold_cnt[i] - 1'b1;
					else hold_end[i] = 1;
					if (rep_cnt[i] != 0) rep_cnt[i] = rep_cnt[i] - 1'b1;
					else rep_end[i] = 1;
				end
				return;
			end
			pressed = (pin == high_mask[b]);

			// debounce: a change starts the countdown, a reversal cancels it
			if (pressed == level_q[b]) begin
				if (deb_run[b] && deb_end[b]) begin
					deb_run[b]  = 0;
					chg_wait[b] = 1;
				end
			end else if (!deb_run[b]) begin
				level_q[b]  = pressed;
				chg_wait[b] = 1;
				deb_cnt[b]  = deb_len;
				deb_end[b]  = 0;
				deb_run[b]  = 1;
			end else begin
				deb_run[b]  = 0;
				chg_wait[b] = 0;
			end

			// confirmed change
			if (chg_wait[b] && deb_end[b]) begin
				level_q[b]  = pressed;
				deb_run[b]  = 0;
				chg_wait[b] = 0;
				if (pressed) begin
					run.push_back(btn_event_t'{b, EV_PRESSED, 1'b0});
					hold_cnt[b] = hold_len;
					hold_end[b] = 0;
					hold_run[b] = 1;
				end else begin
					run.push_back(btn_event_t'{b, EV_RELEASED, 1'b0});
					if (hold_run[b]) run.push_back(btn_event_t'{b, EV_CLICK, 1'b0});
					hold_run[b] = 0;
				end
				rep_run[b] = 0;
			end

			// hold reached, repeat timing starts
			if (level_q[b] && hold_run[b] && !rep_run[b] && hold_end[b]) begin
				run.push_back(btn_event_t'{b, EV_HOLD, 1'b0});
				hold_run[b] = 0;
				rep_cnt[b]  = rep_len;
				rep_end[b]  = 0;
				rep_run[b]  = 1;
			end

			// repeat period elapsed
			if (level_q[b] && !hold_run[b] && rep_run[b] && rep_end[b]) begin
				run.push_back(btn_event_t'{b, EV_REPEAT, 1'b0});
				rep_cnt[b] = rep_len;
				rep_end[b] = 0;
			end

			if (run.size() > 0) run[run.size() - 1].last = 1;
			foreach (run[i]) pending.push_back(run[i]);
		endfunction

		// accepted event word against the oldest expected one
		function void check_event(logic [2:0] btn, logic [2:0] code, logic last);
			btn_event_t want;
			if (pending.size() == 0) begin
				$error("event with nothing expected: button %0d code %0d", btn, code);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (btn !== want.btn) begin
				$error("event_button: expected %0d, actual %0d", want.btn, btn);
				errors++;
			end
			if (code !== want.code) begin
				$error("event_code: expected %0d, actual %0d", want.code, code);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_of_run: expected %0d, actual %0d", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [2:0] button, [3] pin_level, [7:4] zero
	logic        s_tuser;   // [0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [2:0] event_button, [5:3] event_code, [7:6] zero
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	btn_qualifier_model sb = new();
	bit                 no_stall;
	bit                 intent[NUM_BUTTONS];

	button_debounce_hold_repeat_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int draw_gap();
		return no_stall ? 0 : $urandom_range(0, 16);
	endfunction

	// apb write, then the bus is left idle
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// apb read compared with the register value
	task automatic read_check(logic [1:0] idx);
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== sb.reg_value(idx)) begin
			$error("prdata: expected %0h, actual %0h", sb.reg_value(idx), got);
			sb.errors++;
		end
		@(posedge clk);
	endtask

	// write all registers with junk above each register width, then read back
	task automatic program_regs(logic [15:0] deb, logic [15:0] hold, logic [15:0] rep,
			logic [7:0] mask);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(REG_DEBOUNCE, {junk[15:0], deb});
		sb.set_reg(REG_DEBOUNCE, {junk[15:0], deb});
		junk = $urandom;
		write_reg(REG_HOLD, {junk[15:0], hold});
		sb.set_reg(REG_HOLD, {junk[15:0], hold});
		junk = $urandom;
		write_reg(REG_REPEAT, {junk[15:0], rep});
		sb.set_reg(REG_REPEAT, {junk[15:0], rep});
		junk = $urandom;
		write_reg(REG_POLARITY, {junk[23:0], mask});
		sb.set_reg(REG_POLARITY, {junk[23:0], mask});
		for (int i = 0; i < 4; i++) read_check(i[1:0]);
	endtask

	// one input word, valid stays high until accepted
	task automatic send_word(logic kind, logic [2:0] b, logic pin);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {4'b0000, pin, b};
		do @(posedge clk); while (!s_tready);
		sb.note_word(kind, b, pin);
	endtask

	// stop sending, wait for the expected events, then let the block go idle
	task automatic settle();
		int w;
		s_tvalid <= 1'b0;
		for (w = 0; w < DRAIN_LIMIT && sb.pending.size() != 0; w++) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly well-formed press and release sequences on one button, plus ticks and noise
	task automatic run_phase(int n_items);
		int         r;
		logic [2:0] b;
		logic       pin;
		logic [2:0] focus;
		focus = 3'($urandom_range(0, NUM_BUTTONS - 1));
		for (int k = 0; k < n_items; k++) begin
			r   = $urandom_range(0, 99);
			b   = 3'($urandom_range(0, NUM_BUTTONS - 1));
			pin = 1'($urandom_range(0, 1));
			if (r < 40) begin
				send_word(KIND_TICK, b, pin);
			end else if (r < 50) begin
				send_word(KIND_SAMPLE, b, pin);
			end else begin
				if (r < 85) b = focus;
				if ($urandom_range(0, 15) == 0) intent[b] = !intent[b];
				// pin level that reads as the intended state for this polarity
				send_word(KIND_SAMPLE, b, intent[b] ~^ sb.high_mask[b]);
			end
		end
	endtask

	// event sink with random stalls
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// event monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_event(m_tdata[2:0], m_tdata[5:3], m_tlast);
	end

	// main sequence
	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= KIND_SAMPLE;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		no_stall = 0;
		foreach (intent[i]) intent[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values read back
		for (int i = 0; i < 4; i++) read_check(i[1:0]);

		// directed: zero debounce, short hold, zero repeat, mixed polarity
		program_regs(16'd0, 16'd1, 16'd0, 8'hA5);
		// press then release before hold: pressed, then released with click
		send_word(KIND_SAMPLE, 3'd0, 1'b1);
		send_word(KIND_TICK,   3'd5, 1'b0);
		send_word(KIND_SAMPLE, 3'd0, 1'b1);
		send_word(KIND_SAMPLE, 3'd0, 1'b0);
		send_word(KIND_TICK,   3'd2, 1'b1);
		send_word(KIND_SAMPLE, 3'd0, 1'b0);
		// press held through hold and two repeats, then released without click
		send_word(KIND_SAMPLE, 3'd7, 1'b1);
		send_word(KIND_TICK,   3'd0, 1'b0);
		send_word(KIND_SAMPLE, 3'd7, 1'b1);
		send_word(KIND_TICK,   3'd7, 1'b1);
		send_word(KIND_TICK,   3'd0, 1'b0);
		send_word(KIND_SAMPLE, 3'd7, 1'b1);
		send_word(KIND_TICK,   3'd3, 1'b1);
		send_word(KIND_SAMPLE, 3'd7, 1'b1);
		send_word(KIND_TICK,   3'd4, 1'b0);
		send_word(KIND_SAMPLE, 3'd7, 1'b1);
		// bounce cancels a pending change
		send_word(KIND_SAMPLE, 3'd2, 1'b1);
		send_word(KIND_SAMPLE, 3'd2, 1'b0);
		send_word(KIND_TICK,   3'd6, 1'b1);
		send_word(KIND_SAMPLE, 3'd2, 1'b0);
		send_word(KIND_SAMPLE, 3'd7, 1'b0);
		send_word(KIND_TICK,   3'd1, 1'b0);
		send_word(KIND_SAMPLE, 3'd7, 1'b0);
		// active-low button pressed by a low level
		send_word(KIND_SAMPLE, 3'd3, 1'b0);
		send_word(KIND_TICK,   3'd0, 1'b1);
		send_word(KIND_SAMPLE, 3'd3, 1'b0);
		settle();

		// random phases, extremes first
		for (int p = 0; p < 10; p++) begin
			no_stall = (p == 3) || ($urandom_range(0, 3) == 0);
			case (p)
				0: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
				1: program_regs(16'($urandom_range(0, 3)), 16'($urandom_range(0, 6)),
					16'hFFFF, 8'h00);
				2: program_regs(16'd0, 16'd0, 16'd0, 8'($urandom_range(0, 255)));
				default: program_regs(16'($urandom_range(0, 3)), 16'($urandom_range(0, 6)),
					16'($urandom_range(0, 5)), 8'($urandom_range(0, 255)));
			endcase
			run_phase(52);
			settle();
		end

		if (sb.pending.size() != 0) begin
			$error("%0d expected events never arrived", sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
src/bdhr_pkg.sv
src/button_debounce_hold_repeat_top.sv
tb/button_debounce_hold_repeat_top_tb.sv
